// ===== hw/rtl/dfe_pkg.sv =====
// Shared types, register codes and limits for the delimited frame extractor.
package dfe_pkg;

  localparam int MAX_FRAME_DEF     = 64;
  localparam int PATTERN_BYTES_DEF = 7;

  localparam int PAT_W       = 56;
  localparam int LEN_W       = 3;
  localparam int TICK_W      = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 56;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAD_PATTERN  = 3'd0,
    REG_HEAD_LENGTH   = 3'd1,
    REG_END_PATTERN   = 3'd2,
    REG_END_LENGTH    = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       overflow;
  } out_item_t;

  // Zero acts as one, anything above the window size acts as the window size.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] res;
    begin
      res = len;
      if (len == '0) begin
        res = LEN_W'(1);
      end else if (len > max_len) begin
        res = max_len;
      end
      return res;
    end
  endfunction

endpackage

// ===== hw/rtl/dfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/dfe_pattern_match.sv =====
// Compares the newest len bytes of the byte window against a marker pattern.
module dfe_pattern_match #(
  parameter int PATTERN_BYTES = dfe_pkg::PATTERN_BYTES_DEF
) (
  input  logic [PATTERN_BYTES*8-1:0] window,
  input  logic [dfe_pkg::PAT_W-1:0]  pattern,
  input  logic [dfe_pkg::LEN_W-1:0]  len,
  output logic                       hit
);
  import dfe_pkg::*;

  always_comb begin
    logic hit_v;
    hit_v = 1'b1;
    for (int b = 0; b < PATTERN_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        hit_v = hit_v & (window[8*b +: 8] == pattern[8*b +: 8]);
      end
    end
    hit = hit_v;
  end

endmodule

// ===== hw/rtl/delimited_frame_extractor.sv =====
// Start/end delimited frame receiver: finds a head marker in a byte stream, collects the
// frame into an on-chip store until the end marker, then plays the frame back as a run of
// byte items. While hunting for the head or collecting bytes the block takes one item per
// cycle. After a head match the head_length marker bytes (1 to 7) are copied into the frame
// store through its single write port; input is held off then. Playback reads the store
// through its single registered read port, waiting for read data before each byte, and
// holds the input off until the last byte of the frame is loaded for output. While
// collecting, every item (byte or tick) waits as long as the output register still holds
// an item the consumer has not taken. Ticks in idle are dropped; a frame that outlives
// timeout_ticks is discarded without output; overflow of the store gives an overflow item.
module delimited_frame_extractor #(
  parameter int MAX_FRAME     = dfe_pkg::MAX_FRAME_DEF,
  parameter int PATTERN_BYTES = dfe_pkg::PATTERN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dfe_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dfe_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dfe_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int WW = PATTERN_BYTES * 8;
  localparam logic [LEN_W-1:0] PB_LEN  = LEN_W'(PATTERN_BYTES);
  localparam logic [CW-1:0]    PB_CNT  = CW'(PATTERN_BYTES);
  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_FRAME);

  // configuration registers
  logic [PAT_W-1:0]  head_pattern;
  logic [LEN_W-1:0]  head_length;
  logic [PAT_W-1:0]  end_pattern;
  logic [LEN_W-1:0]  end_length;
  logic [TICK_W-1:0] timeout_ticks;

  // control state
  state_t            state, state_next;
  logic [WW-1:0]     window;
  logic [CW-1:0]     frame_count;
  logic [TICK_W-1:0] wait_ticks;
  logic [LEN_W-1:0]  seed_idx;
  logic [AW-1:0]     emit_idx;
  logic              rd_ok;

  logic [LEN_W-1:0]  hl_c, el_c;
  logic [WW-1:0]     win_shift;
  logic              head_match, end_match;
  logic              in_acc, is_byte, is_tick;
  logic [CW-1:0]     cnt_idle_next, stored_next;
  logic              head_hit, end_hit, ovf, seed_last, emit_last;
  logic [TICK_W-1:0] wait_inc;
  logic              timed_out;
  logic [LEN_W-1:0]  seed_sel;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              emit_load, ovf_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pattern  <= '0;
      head_length   <= LEN_W'(1);
      end_pattern   <= '0;
      end_length    <= LEN_W'(1);
      timeout_ticks <= TICK_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAD_PATTERN:  head_pattern  <= cfg_data[PAT_W-1:0];
        REG_HEAD_LENGTH:   head_length   <= cfg_data[LEN_W-1:0];
        REG_END_PATTERN:   end_pattern   <= cfg_data[PAT_W-1:0];
        REG_END_LENGTH:    end_length    <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign hl_c = clamp_len(head_length, PB_LEN);
  assign el_c = clamp_len(end_length, PB_LEN);

  assign in_acc  = in_valid && in_ready;
  assign is_byte = (in_item.mode == MODE_BYTE);
  assign is_tick = (in_item.mode == MODE_TICK);

  assign win_shift = (window << 8) | WW'(in_item.data_byte);

  dfe_pattern_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_head_match (
    .window  (win_shift),
    .pattern (head_pattern),
    .len     (hl_c),
    .hit     (head_match)
  );

  dfe_pattern_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_end_match (
    .window  (win_shift),
    .pattern (end_pattern),
    .len     (el_c),
    .hit     (end_match)
  );

  // idle: frame_count counts window bytes, saturating at the window size
  assign cnt_idle_next = (frame_count < PB_CNT) ? frame_count + CW'(1) : frame_count;
  assign head_hit      = (cnt_idle_next >= CW'(hl_c)) && head_match;

  // end marker only counts once it lies wholly past the head
  assign stored_next = frame_count + CW'(1);
  assign end_hit     = (stored_next >= CW'(hl_c) + CW'(el_c)) && end_match;
  assign ovf         = (frame_count >= MAX_CNT);

  assign wait_inc  = (wait_ticks == '1) ? wait_ticks : wait_ticks + TICK_W'(1);
  assign timed_out = (wait_inc > timeout_ticks);

  assign seed_last = (seed_idx == hl_c - LEN_W'(1));
  assign seed_sel  = hl_c - LEN_W'(1) - seed_idx;
  assign emit_last = (CW'(emit_idx) + CW'(1) == frame_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && is_byte && head_hit) state_next = ST_SEED;
      end
      ST_SEED: begin
        if (seed_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (in_acc) begin
          if (is_tick) begin
            if (timed_out) state_next = ST_IDLE;
          end else if (ovf) begin
            state_next = ST_IDLE;
          end else if (end_hit) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and handshake controls
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = emit_idx;
    emit_load = 1'b0;
    ovf_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(seed_idx);
        ram_wdata = 8'(window >> (8 * seed_sel));
      end
      ST_WAIT: begin
        in_ready = !out_valid || out_ready;
        if (in_acc && is_byte) begin
          if (ovf) begin
            ovf_load = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = frame_count[AW-1:0];
            ram_wdata = in_item.data_byte;
          end
        end
      end
      ST_EMIT: begin
        emit_load = rd_ok && (!out_valid || out_ready);
      end
      default: ;
    endcase
  end

  dfe_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window      <= '0;
      frame_count <= '0;
      wait_ticks  <= '0;
      seed_idx    <= '0;
      emit_idx    <= '0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // read data lines up with emit_idx in the cycle after the address settles
      rd_ok <= (state == ST_EMIT) && !emit_load;
      if (emit_load || ovf_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && is_byte) begin
            window      <= win_shift;
            frame_count <= cnt_idle_next;
            if (head_hit) begin
              frame_count <= CW'(hl_c);
              wait_ticks  <= '0;
              seed_idx    <= '0;
            end
          end
        end
        ST_SEED: begin
          seed_idx <= seed_idx + LEN_W'(1);
          if (seed_last) window <= '0;
        end
        ST_WAIT: begin
          if (in_acc) begin
            if (is_tick) begin
              wait_ticks <= wait_inc;
              if (timed_out) begin
                window      <= '0;
                frame_count <= '0;
                wait_ticks  <= '0;
              end
            end else if (ovf) begin
              window      <= '0;
              frame_count <= '0;
              wait_ticks  <= '0;
            end else begin
              window      <= win_shift;
              frame_count <= stored_next;
              if (end_hit) begin
                window   <= '0;
                emit_idx <= '0;
              end
            end
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            emit_idx <= emit_idx + AW'(1);
            if (emit_last) begin
              frame_count <= '0;
              wait_ticks  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_item.frame_byte <= ram_rdata;
      out_item.last       <= emit_last;
      out_item.overflow   <= 1'b0;
    end else if (ovf_load) begin
      out_item.frame_byte <= '0;
      out_item.last       <= 1'b1;
      out_item.overflow   <= 1'b1;
    end
  end

  // store writes stay inside the frame
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) < MAX_CNT))
    else $error("frame store write beyond frame size");

  // playback only runs over a non-empty, in-range frame
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (frame_count != '0 && frame_count <= MAX_CNT))
    else $error("playback with bad frame length");

  // read data is only flagged good during playback
  assert property (@(posedge clk) disable iff (rst)
    rd_ok |-> (state == ST_EMIT))
    else $error("read data flagged outside playback");

  // the final byte of a frame returns the block to hunting with a clean count
  assert property (@(posedge clk) disable iff (rst)
    (emit_load && emit_last) |=> (state == ST_IDLE && frame_count == '0))
    else $error("no return to idle after last frame byte");

  // seeding never runs past the head length
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |-> (seed_idx < hl_c))
    else $error("seed index beyond head length");

  // a loaded item never overwrites one the consumer has not taken
  assert property (@(posedge clk) disable iff (rst)
    (emit_load || ovf_load) |-> (!out_valid || out_ready))
    else $error("output item overwritten");

endmodule
